// File: hdl/bitmap_run_allocator_unit_assert.svh
// Assertion macros shared by the allocator RTL.
// Depends on nothing; users supply aclk and aresetn in scope.
`ifndef BITMAP_RUN_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_RUN_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BRAU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication, checked out of reset
`define BRAU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// File: hdl/brau_pkg.sv
// Shared types and constants for the bitmap run allocator.
// No dependencies.
`timescale 1ns / 1ps

package brau_pkg;

    localparam int IDX_W     = 10;
    localparam int RUN_LEN_W = 11;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 8;   // width of the used-bytes register
    localparam int START_W   = CNT_W + 3;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_TEST  = 2'd1,
        CMD_SCAN  = 2'd2,
        CMD_WRITE = 2'd3
    } cmd_t;

    // per-byte outcome of the run search
    typedef struct packed {
        logic               hit;
        logic [START_W-1:0] start;
    } scan_res_t;

endpackage

// File: hdl/bitmap_run_allocator_unit.sv
// Bitmap run allocator. An occupancy bitmap of MAP_BYTES bytes sits in one
// synchronous RAM; bit i is bit i%8 of byte i/8. One command word is worked
// at a time; a finished result waits in the output register while the next
// word is taken. Test and write pass through a RAM read, then a read-modify-write,
// before the result. A scan walks the RAM one byte per cycle through its read
// port and ends at the first fit or after the last used byte. Clear sweeps the
// RAM one byte a cycle. After reset the same sweep runs before s_tready rises;
// cfg writes are taken at any time.
// Depends on brau_pkg, brau_ram, brau_run_scan and the assertion header.
`timescale 1ns / 1ps
`include "bitmap_run_allocator_unit_assert.svh"

module bitmap_run_allocator_unit #(
    parameter int MAP_BYTES = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    // command words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // bit_index[9:0], run_length[20:10], write_value[21]
    input  logic [1:0]  s_tuser,    // command[1:0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // run_start[9:0], bit_value[10]
    output logic        m_tuser,    // found[0]
    // used_bytes register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int AddrW   = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int MapBits = MAP_BYTES * 8;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CLEAR  = 6'b000010,
        ST_READ   = 6'b000100,
        ST_MODIFY = 6'b001000,
        ST_SCAN   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [brau_pkg::CNT_W-1:0] used_reg, used_next;
    logic [AddrW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic                       clr_cmd_reg, clr_cmd_next;
    logic [brau_pkg::CNT_W-1:0] issue_reg, issue_next;
    logic [brau_pkg::CNT_W-1:0] proc_reg, proc_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic                       m_tvalid_reg, m_tvalid_next;

    brau_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [brau_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [brau_pkg::RUN_LEN_W-1:0]  len_reg, len_next;
    logic                            val_reg, val_next;
    logic                            res_found_reg, res_found_next;
    logic [brau_pkg::IDX_W-1:0]      res_start_reg, res_start_next;
    logic                            res_bit_reg, res_bit_next;
    logic                            m_found_reg, m_found_next;
    logic [brau_pkg::IDX_W-1:0]      m_start_reg, m_start_next;
    logic                            m_bit_reg, m_bit_next;

    logic                            s_accept;
    logic [brau_pkg::CNT_W-1:0]      eff;
    logic                            in_used;
    logic                            in_map;
    logic [AddrW-1:0]                byte_addr;
    logic [brau_pkg::BYTE_W-1:0]     bit_mask;

    logic                            ram_we, ram_re;
    logic [AddrW-1:0]                ram_waddr, ram_raddr;
    logic [brau_pkg::BYTE_W-1:0]     ram_wdata, ram_rdata;

    logic                            scan_start;
    logic                            scan_vld;
    brau_pkg::scan_res_t             scan_res;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_found_reg;
    assign m_tdata   = {5'd0, m_bit_reg, m_start_reg};

    // register values above the map count as the whole map
    assign eff = (32'(used_reg) > MAP_BYTES) ? brau_pkg::CNT_W'(MAP_BYTES) : used_reg;
    assign in_used   = {1'b0, idx_reg} < {eff, 3'b000};
    assign in_map    = 32'(idx_reg) < MapBits;
    assign byte_addr = AddrW'(idx_reg[brau_pkg::IDX_W-1:3]);
    assign bit_mask  = brau_pkg::BYTE_W'(1) << idx_reg[2:0];

    assign scan_start = s_accept && (brau_pkg::cmd_t'(s_tuser) == brau_pkg::CMD_SCAN);
    assign scan_vld   = rd_vld_reg && (state_reg == ST_SCAN);

    brau_ram #(
        .WIDTH (brau_pkg::BYTE_W),
        .DEPTH (MAP_BYTES)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    brau_run_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (scan_start),
        .byte_valid (scan_vld),
        .byte_num   (proc_reg),
        .byte_data  (ram_rdata),
        .run_len    (len_reg),
        .res        (scan_res)
    );

    always_comb begin
        state_next     = state_reg;
        used_next      = used_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_cmd_next   = clr_cmd_reg;
        issue_next     = issue_reg;
        proc_next      = proc_reg;
        rd_vld_next    = 1'b0;
        m_tvalid_next  = m_tvalid_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        val_next       = val_reg;
        res_found_next = res_found_reg;
        res_start_next = res_start_reg;
        res_bit_next   = res_bit_reg;
        m_found_next   = m_found_reg;
        m_start_next   = m_start_reg;
        m_bit_next     = m_bit_reg;
        ram_we         = 1'b0;
        ram_waddr      = byte_addr;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = byte_addr;

        if (cfg_valid) begin
            used_next = cfg_data;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd_next       = brau_pkg::cmd_t'(s_tuser);
                    idx_next       = s_tdata[9:0];
                    len_next       = s_tdata[20:10];
                    val_next       = s_tdata[21];
                    res_found_next = 1'b1;
                    res_start_next = '0;
                    res_bit_next   = 1'b0;
                    issue_next     = '0;
                    proc_next      = '0;
                    unique case (brau_pkg::cmd_t'(s_tuser)) inside
                        brau_pkg::CMD_CLEAR: begin
                            clr_cnt_next = '0;
                            clr_cmd_next = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        brau_pkg::CMD_SCAN: begin
                            if ((s_tdata[20:10] == '0) || (eff == '0)) begin
                                res_found_next = 1'b0;
                                state_next     = ST_DONE;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        brau_pkg::CMD_TEST, brau_pkg::CMD_WRITE: begin
                            state_next = ST_READ;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AddrW'(1);
                if (clr_cnt_reg == AddrW'(MAP_BYTES - 1)) begin
                    // the reset sweep ends silently, a clear command answers
                    state_next   = clr_cmd_reg ? ST_DONE : ST_IDLE;
                    clr_cmd_next = 1'b0;
                end
            end
            ST_READ: begin
                ram_re     = 1'b1;
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                if (cmd_reg == brau_pkg::CMD_TEST) begin
                    res_bit_next = in_used & ram_rdata[idx_reg[2:0]];
                end else if (in_map) begin
                    ram_we    = 1'b1;
                    ram_wdata = val_reg ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
                end
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                // reads run one byte ahead of the search datapath
                ram_raddr = AddrW'(issue_reg);
                if (issue_reg < eff) begin
                    ram_re      = 1'b1;
                    issue_next  = issue_reg + brau_pkg::CNT_W'(1);
                    rd_vld_next = 1'b1;
                end
                if (scan_vld) begin
                    proc_next = proc_reg + brau_pkg::CNT_W'(1);
                    if (scan_res.hit) begin
                        res_start_next = scan_res.start[brau_pkg::IDX_W-1:0];
                        state_next     = ST_DONE;
                    end else if (proc_reg == eff - brau_pkg::CNT_W'(1)) begin
                        res_found_next = 1'b0;
                        state_next     = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = res_found_reg;
                    m_start_next  = res_start_reg;
                    m_bit_next    = res_bit_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            used_reg     <= 8'd128;
            clr_cnt_reg  <= '0;
            clr_cmd_reg  <= 1'b0;
            issue_reg    <= '0;
            proc_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_cmd_reg  <= clr_cmd_next;
            issue_reg    <= issue_next;
            proc_reg     <= proc_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        len_reg       <= len_next;
        val_reg       <= val_next;
        res_found_reg <= res_found_next;
        res_start_reg <= res_start_next;
        res_bit_reg   <= res_bit_next;
        m_found_reg   <= m_found_next;
        m_start_reg   <= m_start_next;
        m_bit_reg     <= m_bit_next;
    end

    `BRAU_ASSERT_IMPL(a_no_write_in_scan, state_reg == ST_SCAN, !ram_we)
    `BRAU_ASSERT_IMPL(a_scan_read_in_range, (state_reg == ST_SCAN) && ram_re, issue_reg < eff)
    `BRAU_ASSERT_NEXT(a_accept_leaves_idle, s_accept, state_reg != ST_IDLE)
    `BRAU_ASSERT_NEXT(a_done_loads_output,
        (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready), m_tvalid_reg)

endmodule

// File: hdl/brau_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module brau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/brau_run_scan.sv
// Run search datapath: folds one bitmap byte per cycle, while byte_valid is high, into a free-bit count.
// Depends on brau_pkg.
`timescale 1ns / 1ps

module brau_run_scan (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,      // clears the running count
    input  logic                            byte_valid,
    input  logic [brau_pkg::CNT_W-1:0]      byte_num,
    input  logic [brau_pkg::BYTE_W-1:0]     byte_data,
    input  logic [brau_pkg::RUN_LEN_W-1:0]  run_len,
    output brau_pkg::scan_res_t             res
);

    // count never exceeds run_len plus one byte
    logic [11:0] count_reg;
    logic [11:0] count_next;
    logic [11:0] cnt_j;
    logic [3:0]  zrun;
    logic        allz;
    logic        hit;
    logic [2:0]  hit_j;

    always_comb begin
        zrun  = 4'd0;
        allz  = 1'b1;
        hit   = 1'b0;
        hit_j = 3'd0;
        cnt_j = count_reg;
        for (int j = 0; j < brau_pkg::BYTE_W; j++) begin
            if (byte_data[j]) begin
                zrun = 4'd0;
                allz = 1'b0;
            end else begin
                zrun = zrun + 4'd1;
            end
            // zeros from byte start continue the run carried in
            cnt_j = allz ? (count_reg + 12'(j + 1)) : 12'(zrun);
            if (!hit && (cnt_j == {1'b0, run_len})) begin
                hit   = 1'b1;
                hit_j = 3'(j);
            end
        end
    end

    assign res.hit   = byte_valid & hit;
    assign res.start = {byte_num, hit_j} + 11'd1 - run_len;

    always_comb begin
        count_next = count_reg;
        if (start) begin
            count_next = 12'd0;
        end else if (byte_valid) begin
            count_next = cnt_j;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 12'd0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// File: bench/tb_bitmap_run_allocator_unit.sv
// Testbench for bitmap_run_allocator_unit: drives command words with bursty timing and
// checks each result word against a cycle-free model of the occupancy map and first-fit scan.
// Depends on brau_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_bitmap_run_allocator_unit;

    localparam int MAP_BYTES   = 128;
    localparam int MAP_BITS    = MAP_BYTES * 8;
    localparam int RANDOM_WORDS = 1900;
    // slowest legal run: ~1930 words, each with its longest scan or clear, gap and stall,
    // plus the clearing sweep after reset and the config pauses; taken ~4x over
    localparam int CYCLE_LIMIT = 1_500_000;

    typedef struct packed {
        brau_pkg::cmd_t command;
        logic [9:0]     bit_index;
        logic [10:0]    run_length;
        logic           write_value;
    } cmd_word_t;

    typedef struct packed {
        logic       found;
        logic [9:0] run_start;
        logic       bit_value;
    } result_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = brau_pkg::CMD_CLEAR;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    bitmap_run_allocator_unit #(
        .MAP_BYTES(MAP_BYTES)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // model state
    logic [MAP_BITS-1:0] occ_map = '0;
    logic [7:0]          used_reg = 8'd128;

    cmd_word_t    pending_q[$];
    result_word_t expected_q[$];
    cmd_word_t    drv_word = '0;
    logic         s_taken = 1'b0;
    int           errors = 0;
    int           word_count = 0;
    int           cycle_cnt = 0;
    int           burst_left = 1;
    int           gap_left = 0;
    int           stall_mode = 0;
    int           mode_left = 0;
    int           stall_left = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic int used_bit_count();
        return (used_reg > MAP_BYTES) ? MAP_BITS : int'(used_reg) * 8;
    endfunction

    // apply one command word to the model map and return its result word
    function automatic result_word_t apply_word(cmd_word_t w);
        result_word_t r;
        int ub;
        int len;
        int run;
        r.found = 1'b1;
        r.run_start = '0;
        r.bit_value = 1'b0;
        ub = used_bit_count();
        len = int'(w.run_length);
        case (w.command)
            brau_pkg::CMD_CLEAR: begin
                occ_map = '0;
            end
            brau_pkg::CMD_TEST: begin
                if (int'(w.bit_index) < ub)
                    r.bit_value = occ_map[w.bit_index];
            end
            brau_pkg::CMD_SCAN: begin
                r.found = 1'b0;
                if (len != 0 && len <= ub) begin
                    run = 0;
                    for (int i = 0; i < ub; i++) begin
                        run = occ_map[i] ? 0 : run + 1;
                        if (run == len) begin
                            r.found = 1'b1;
                            r.run_start = 10'(i + 1 - len);
                            break;
                        end
                    end
                end
            end
            brau_pkg::CMD_WRITE: begin
                if (int'(w.bit_index) < MAP_BITS)
                    occ_map[w.bit_index] = w.write_value;
            end
        endcase
        return r;
    endfunction

    // driver: bursts of words separated by random gaps
    always @(negedge aclk) begin
        cmd_word_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_q.size() > 0) begin
                nxt = pending_q.pop_front();
                drv_word <= nxt;
                s_tdata  <= {2'b00, nxt.write_value, nxt.run_length, nxt.bit_index};
                s_tuser  <= nxt.command;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure: always ready, random, or long stalls
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(64, 256);
        end else begin
            mode_left = mode_left - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 7);
            default: begin
                if (stall_left > 0) begin
                    stall_left = stall_left - 1;
                    m_tready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(1, 20);
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // monitor: predict on every accepted command word, check every accepted result word
    always @(posedge aclk) begin
        result_word_t want;
        s_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                used_reg = cfg_data;
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_word(drv_word));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result word with no command pending");
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_tuser !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, m_tuser);
                        errors++;
                    end
                    if (m_tdata[9:0] !== want.run_start) begin
                        $error("run_start: expected %0d, got %0d", want.run_start, m_tdata[9:0]);
                        errors++;
                    end
                    if (m_tdata[10] !== want.bit_value) begin
                        $error("bit_value: expected %0d, got %0d", want.bit_value, m_tdata[10]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_word(brau_pkg::cmd_t c, int idx, int len, bit v);
        cmd_word_t w;
        w.command     = c;
        w.bit_index   = idx[9:0];
        w.run_length  = len[10:0];
        w.write_value = v;
        pending_q.push_back(w);
        word_count++;
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0);
    endtask

    task automatic set_used(int v);
        wait_idle();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v[7:0];
        do @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_len(int ub);
        int r;
        r = $urandom_range(0, 99);
        if (ub < 1)
            return $urandom_range(0, 8);
        if (r < 60)
            return $urandom_range(1, (ub < 8) ? ub : 8);
        if (r < 85)
            return $urandom_range(1, ub);
        if (r < 95)
            return (ub > 2) ? $urandom_range(ub - 2, ub + 2) : $urandom_range(0, ub + 2);
        return $urandom_range(0, 2047);
    endfunction

    function automatic int pick_index(int ub);
        if (ub < 8 || $urandom_range(0, 99) < 15)
            return $urandom_range(0, MAP_BITS - 1);
        return $urandom_range(0, ub - 1);
    endfunction

    task automatic random_phase();
        int r;
        int ub;
        int words;
        int start;
        int n;
        r = $urandom_range(0, 19);
        if (r == 0)
            set_used(0);
        else if (r == 1)
            set_used($urandom_range(129, 255));
        else if (r == 2)
            set_used(128);
        else if (r == 3)
            set_used(1);
        else if (r < 12)
            set_used($urandom_range(1, 8));
        else if (r < 17)
            set_used($urandom_range(9, 32));
        else
            set_used($urandom_range(33, 128));
        ub = used_bit_count();
        if ($urandom_range(0, 9) < 6)
            push_word(brau_pkg::CMD_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 2047),
                      1'($urandom_range(0, 1)));
        words = $urandom_range(40, 120);
        for (int k = 0; k < words; k++) begin
            r = $urandom_range(0, 99);
            if (r < 12 || (r >= 18 && r < 20)) begin
                // run of ones, or an aligned full byte of ones
                if (r < 12) begin
                    start = pick_index(ub);
                    n = $urandom_range(1, 16);
                end else begin
                    start = (ub >= 8) ? $urandom_range(0, ub / 8 - 1) * 8 : 0;
                    n = 8;
                end
                for (int b = start; b < start + n && b < MAP_BITS; b++)
                    push_word(brau_pkg::CMD_WRITE, b, $urandom_range(0, 2047), 1'b1);
            end else if (r < 18) begin
                start = pick_index(ub);
                n = $urandom_range(1, 12);
                for (int b = start; b < start + n && b < MAP_BITS; b++)
                    push_word(brau_pkg::CMD_WRITE, b, $urandom_range(0, 2047), 1'b0);
            end else if (r < 45) begin
                push_word(brau_pkg::CMD_SCAN, $urandom_range(0, 1023), pick_len(ub),
                          1'($urandom_range(0, 1)));
            end else if (r < 65) begin
                push_word(brau_pkg::CMD_TEST, pick_index(ub + 8), $urandom_range(0, 2047),
                          1'($urandom_range(0, 1)));
            end else if (r < 90) begin
                push_word(brau_pkg::CMD_WRITE, pick_index(ub), $urandom_range(0, 2047),
                          ($urandom_range(0, 9) < 6));
            end else if (r < 92) begin
                push_word(brau_pkg::CMD_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 2047),
                          1'($urandom_range(0, 1)));
            end else begin
                push_word(brau_pkg::CMD_SCAN, $urandom_range(0, 1023), $urandom_range(0, 2047),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: edges of the map, zero and oversize runs, clear, range limits
        push_word(brau_pkg::CMD_TEST, 0, 0, 1'b0);
        push_word(brau_pkg::CMD_SCAN, 0, 1, 1'b0);
        push_word(brau_pkg::CMD_WRITE, 0, 0, 1'b1);
        push_word(brau_pkg::CMD_TEST, 0, 0, 1'b0);
        push_word(brau_pkg::CMD_SCAN, 0, 1, 1'b0);
        push_word(brau_pkg::CMD_WRITE, 1023, 2047, 1'b1);
        push_word(brau_pkg::CMD_TEST, 1023, 0, 1'b0);
        push_word(brau_pkg::CMD_SCAN, 0, 1022, 1'b0);
        push_word(brau_pkg::CMD_SCAN, 0, 1023, 1'b0);
        push_word(brau_pkg::CMD_SCAN, 0, 1024, 1'b0);
        push_word(brau_pkg::CMD_SCAN, 0, 0, 1'b0);
        push_word(brau_pkg::CMD_SCAN, 1023, 2047, 1'b1);
        push_word(brau_pkg::CMD_WRITE, 0, 0, 1'b0);
        push_word(brau_pkg::CMD_WRITE, 1023, 0, 1'b0);
        push_word(brau_pkg::CMD_SCAN, 0, 1024, 1'b0);
        push_word(brau_pkg::CMD_WRITE, 100, 0, 1'b1);
        push_word(brau_pkg::CMD_CLEAR, 0, 0, 1'b0);
        push_word(brau_pkg::CMD_TEST, 100, 0, 1'b0);
        set_used(1);
        push_word(brau_pkg::CMD_WRITE, 100, 0, 1'b1);    // stored above the used range
        push_word(brau_pkg::CMD_TEST, 100, 0, 1'b0);
        push_word(brau_pkg::CMD_TEST, 7, 0, 1'b0);
        push_word(brau_pkg::CMD_SCAN, 0, 8, 1'b0);
        push_word(brau_pkg::CMD_SCAN, 0, 9, 1'b0);
        set_used(0);
        push_word(brau_pkg::CMD_SCAN, 0, 1, 1'b0);
        push_word(brau_pkg::CMD_TEST, 0, 0, 1'b0);
        set_used(255);                          // clamps to the full map
        push_word(brau_pkg::CMD_TEST, 100, 0, 1'b0);
        push_word(brau_pkg::CMD_SCAN, 0, 1024, 1'b0);

        word_count = 0;
        while (word_count < RANDOM_WORDS)
            random_phase();

        wait_idle();
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
